FILE: hw/rtl/camera_parallel_capture_decimator_unit_macros.svh
// assertion macros for the checker file
`ifndef CAMERA_PARALLEL_CAPTURE_DECIMATOR_UNIT_MACROS_SVH
`define CAMERA_PARALLEL_CAPTURE_DECIMATOR_UNIT_MACROS_SVH

// checked property, quiet while reset is high
`define CPCD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("cpcd assertion failed");

// checked property that also holds across reset
`define CPCD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("cpcd assertion failed");

`endif

FILE: hw/rtl/cpcd_pkg.sv
// shared types and constants for the camera capture decimator
`default_nettype none

package cpcd_pkg;

   // field widths
   localparam int LineCountWidth  = 9;
   localparam int PixelCountWidth = 10;
   localparam int AddrWidth       = 18;
   localparam int DataWidth       = 8;
   localparam int CsrIndexWidth   = 1;
   localparam int CsrDataWidth    = 10;

   // register reset values
   localparam logic [LineCountWidth-1:0]  LineCountReset  = 9'd120;
   localparam logic [PixelCountWidth-1:0] PixelCountReset = 10'd160;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] CsrLineCount  = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CsrPixelCount = 1'd1;

   // default limits
   localparam int MaxLinesDefault  = 256;
   localparam int MaxPixelsDefault = 512;

   // one sampled pin word
   typedef struct packed {
      logic                 start_req;
      logic                 vsync;
      logic                 hsync;
      logic                 pixel_clock;
      logic [DataWidth-1:0] data_byte;
   } req_type;

   // one result word
   typedef struct packed {
      logic                 byte_valid;
      logic [AddrWidth-1:0] byte_address;
      logic [DataWidth-1:0] byte_data;
      logic                 frame_done;
      logic                 busy_res;
   } rsp_type;

   // configuration handed to the sequencer
   typedef struct packed {
      logic [LineCountWidth-1:0]  line_count;
      logic [PixelCountWidth-1:0] pixel_count;
   } cfg_type;

endpackage

`default_nettype wire

FILE: hw/rtl/cpcd_csr.sv
// configuration registers for line and pixel counts
`default_nettype none

module cpcd_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [cpcd_pkg::CsrIndexWidth-1:0]   csr_index,
   input  wire logic [cpcd_pkg::CsrDataWidth-1:0]    csr_wdata,
   output cpcd_pkg::cfg_type                         cfg
);

   cpcd_pkg::cfg_type cfg_ff;
   cpcd_pkg::cfg_type cfg_in;

   // writes are always taken
   assign csr_ready = 1'b1;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            cpcd_pkg::CsrLineCount: begin
               cfg_in.line_count = csr_wdata[cpcd_pkg::LineCountWidth-1:0];
            end
            cpcd_pkg::CsrPixelCount: begin
               cfg_in.pixel_count = csr_wdata[cpcd_pkg::PixelCountWidth-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_count  <= cpcd_pkg::LineCountReset;
         cfg_ff.pixel_count <= cpcd_pkg::PixelCountReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/cpcd_seq.sv
// capture sequencer: sync waits, byte capture, pixel and line counting
`default_nettype none

module cpcd_seq #(
   parameter int MAX_LINES  = cpcd_pkg::MaxLinesDefault,
   parameter int MAX_PIXELS = cpcd_pkg::MaxPixelsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  cpcd_pkg::req_type word,
   input  cpcd_pkg::cfg_type cfg,
   output cpcd_pkg::rsp_type result
);

   localparam int LineCntWidth  = $clog2(MAX_LINES + 1);
   localparam int PixCntWidth   = $clog2(MAX_PIXELS + 1);
   localparam int LineCmpWidth  = (LineCntWidth > cpcd_pkg::LineCountWidth) ?
                                  LineCntWidth : cpcd_pkg::LineCountWidth;
   localparam int PixCmpWidth   = (PixCntWidth > cpcd_pkg::PixelCountWidth) ?
                                  PixCntWidth : cpcd_pkg::PixelCountWidth;

   // sequencer states
   localparam logic [3:0] StIdle  = 4'd0;
   localparam logic [3:0] StVsHi  = 4'd1;
   localparam logic [3:0] StVsLo  = 4'd2;
   localparam logic [3:0] StHsHi1 = 4'd3;
   localparam logic [3:0] StHsLo  = 4'd4;
   localparam logic [3:0] StHsHi2 = 4'd5;
   localparam logic [3:0] StPaHi  = 4'd6;
   localparam logic [3:0] StPaLo  = 4'd7;
   localparam logic [3:0] StPbHi  = 4'd8;
   localparam logic [3:0] StPbLo  = 4'd9;
   localparam logic [3:0] StS1Hi  = 4'd10;
   localparam logic [3:0] StS1Lo  = 4'd11;
   localparam logic [3:0] StS2Hi  = 4'd12;
   localparam logic [3:0] StS2Lo  = 4'd13;

   logic [3:0]                        state_ff, state_in;
   logic [LineCntWidth-1:0]           line_ff, line_in;
   logic [PixCntWidth-1:0]            pix_ff, pix_in;
   logic [cpcd_pkg::AddrWidth-1:0]    addr_ff, addr_in;

   logic [LineCmpWidth-1:0]           line_limit;
   logic [PixCmpWidth-1:0]            pix_limit;
   logic [LineCntWidth-1:0]           line_next;
   logic [PixCntWidth-1:0]            pix_next;

   // effective limits: zero reads as one, large values clamp to the maximum
   always_comb begin
      line_limit = LineCmpWidth'(cfg.line_count);
      if (cfg.line_count == '0) begin
         line_limit = LineCmpWidth'(1);
      end else if (LineCmpWidth'(cfg.line_count) > LineCmpWidth'(MAX_LINES)) begin
         line_limit = LineCmpWidth'(MAX_LINES);
      end
      pix_limit = PixCmpWidth'(cfg.pixel_count);
      if (cfg.pixel_count == '0) begin
         pix_limit = PixCmpWidth'(1);
      end else if (PixCmpWidth'(cfg.pixel_count) > PixCmpWidth'(MAX_PIXELS)) begin
         pix_limit = PixCmpWidth'(MAX_PIXELS);
      end
   end

   assign line_next = line_ff + LineCntWidth'(1);
   assign pix_next  = pix_ff + PixCntWidth'(1);

   // next state and result for the word in the input register
   always_comb begin
      state_in = state_ff;
      line_in  = line_ff;
      pix_in   = pix_ff;
      addr_in  = addr_ff;
      result   = '0;
      unique case (state_ff)
         StIdle: begin
            if (word.start_req) begin
               state_in = StVsHi;
            end
         end
         StVsHi: begin
            if (word.vsync) begin
               state_in = StVsLo;
            end
         end
         StVsLo: begin
            if (!word.vsync) begin
               addr_in  = '0;
               line_in  = '0;
               state_in = StHsHi1;
            end
         end
         StHsHi1: begin
            if (word.hsync) begin
               state_in = StHsLo;
            end
         end
         StHsLo: begin
            if (!word.hsync) begin
               state_in = StHsHi2;
            end
         end
         StHsHi2: begin
            if (word.hsync) begin
               pix_in   = '0;
               state_in = StPaHi;
            end
         end
         StPaHi, StPbHi: begin
            if (word.pixel_clock) begin
               result.byte_valid   = 1'b1;
               result.byte_address = addr_ff;
               result.byte_data    = word.data_byte;
               addr_in             = addr_ff + cpcd_pkg::AddrWidth'(1);
               state_in            = state_ff + 4'd1;
            end
         end
         StS1Hi, StS2Hi: begin
            if (word.pixel_clock) begin
               state_in = state_ff + 4'd1;
            end
         end
         StPaLo, StPbLo, StS1Lo: begin
            if (!word.pixel_clock) begin
               state_in = state_ff + 4'd1;
            end
         end
         StS2Lo: begin
            if (!word.pixel_clock) begin
               pix_in = pix_next;
               if (PixCmpWidth'(pix_next) >= pix_limit) begin
                  line_in = line_next;
                  if (LineCmpWidth'(line_next) >= line_limit) begin
                     result.frame_done = 1'b1;
                     state_in          = StIdle;
                  end else begin
                     state_in = StHsHi1;
                  end
               end else begin
                  state_in = StPaHi;
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
      result.busy_res = (state_in != StIdle);
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         line_ff  <= '0;
         pix_ff   <= '0;
         addr_ff  <= '0;
      end else if (step) begin
         state_ff <= state_in;
         line_ff  <= line_in;
         pix_ff   <= pix_in;
         addr_ff  <= addr_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/camera_parallel_capture_decimator_unit.sv
// top level of the parallel camera capture decimator
//
// Usage: each req word carries one sample of the camera pins (vsync, hsync,
// pixel clock level, data byte) plus a start request. Every accepted word
// gives exactly one rsp word: byte_valid with byte_address and byte_data
// when a kept byte was captured, frame_done on the word that ends a frame,
// and busy_res while a capture is armed or running.
// Pipeline: an accepted word goes into the input register, the sequencer
// steps it into the result register and rsp shows it. Throughput: one word
// per cycle while rsp_stall is low.
// Configuration: csr writes set the kept line count (index 0) and the kept
// pixel count (index 1); csr_ready is always high. Write only while idle.
// Reset: synchronous and active high; clears the pipeline, the sequencer
// (to idle) and loads line count 120 and pixel count 160.
// Stall: when rsp_stall holds, the result register keeps its word and
// req_stall rises once the input register is also full; no word is lost.
`default_nettype none

module camera_parallel_capture_decimator_unit #(
   parameter int MAX_LINES  = cpcd_pkg::MaxLinesDefault,
   parameter int MAX_PIXELS = cpcd_pkg::MaxPixelsDefault
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  cpcd_pkg::req_type                        req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output cpcd_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [cpcd_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [cpcd_pkg::CsrDataWidth-1:0]   csr_wdata
);

   cpcd_pkg::cfg_type cfg;
   cpcd_pkg::rsp_type step_result;

   logic              in_valid_ff, in_valid_in;
   cpcd_pkg::req_type in_data_ff;
   logic              out_valid_ff, out_valid_in;
   cpcd_pkg::rsp_type out_data_ff;
   logic              out_free;
   logic              step;
   logic              accept;

   // handshake between input register and result register
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !step);
   assign out_valid_in = step || (out_valid_ff && rsp_stall);

   // configuration registers
   cpcd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer
   cpcd_seq #(
      .MAX_LINES  (MAX_LINES),
      .MAX_PIXELS (MAX_PIXELS)
   ) u_seq (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .word   (in_data_ff),
      .cfg    (cfg),
      .result (step_result)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/cpcd_checker.sv
// port-level checks for the camera capture decimator
`default_nettype none

`include "camera_parallel_capture_decimator_unit_macros.svh"

module cpcd_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input cpcd_pkg::rsp_type      rsp_data
);

   // a stalled result word stays put
   `CPCD_ASSERT(rsp_hold_chk, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))

   // the frame-ending word already shows idle
   `CPCD_ASSERT(done_idle_chk, clock, reset, rsp_valid && rsp_data.frame_done |-> !rsp_data.busy_res)

   // a captured byte only appears mid-frame
   `CPCD_ASSERT(byte_busy_chk, clock, reset, rsp_valid && rsp_data.byte_valid |-> rsp_data.busy_res && !rsp_data.frame_done)

   // no capture means zero address and data
   `CPCD_ASSERT(byte_zero_chk, clock, reset, rsp_valid && !rsp_data.byte_valid |-> rsp_data.byte_address == '0 && rsp_data.byte_data == '0)

   // reset empties the result register
   `CPCD_ASSERT_ALWAYS(reset_empty_chk, clock, reset |=> !rsp_valid)

endmodule

bind camera_parallel_capture_decimator_unit cpcd_checker u_cpcd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

FILE: tb/tb_camera_parallel_capture_decimator_unit.sv
// self-checking testbench for the camera capture decimator: steered pin streams
`timescale 1ns / 1ps

module tb_camera_parallel_capture_decimator_unit;

   localparam int HalfPeriod = 4;
   localparam int LongHold   = 60;
   localparam int ReportCap  = 40;
   localparam int ReqBits    = $bits(cpcd_pkg::req_type);

   // capture sequencer steps as tracked by the testbench
   typedef enum logic [3:0] {
      SEQ_IDLE, SEQ_VS_HI, SEQ_VS_LO, SEQ_HS_HI1, SEQ_HS_LO, SEQ_HS_HI2,
      SEQ_PA_HI, SEQ_PA_LO, SEQ_PB_HI, SEQ_PB_LO,
      SEQ_S1_HI, SEQ_S1_LO, SEQ_S2_HI, SEQ_S2_LO
   } seq_step_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   cpcd_pkg::req_type                  req_data = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   cpcd_pkg::rsp_type                  rsp_data;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [cpcd_pkg::CsrIndexWidth-1:0] csr_index = '0;
   logic [cpcd_pkg::CsrDataWidth-1:0]  csr_wdata = '0;

   // pin words waiting to be sent and result words still owed by the block
   cpcd_pkg::req_type pin_words[$];
   cpcd_pkg::rsp_type capture_results_q[$];

   // tracked sequencer state and register copies
   seq_step_type                         seq_now = SEQ_IDLE;
   int                                   lines_done = 0;
   int                                   pixels_done = 0;
   logic [cpcd_pkg::AddrWidth-1:0]       next_addr = '0;
   logic [cpcd_pkg::LineCountWidth-1:0]  line_cfg = cpcd_pkg::LineCountReset;
   logic [cpcd_pkg::PixelCountWidth-1:0] pixel_cfg = cpcd_pkg::PixelCountReset;

   int  mismatch_count = 0;
   bit  req_fire = 1'b0;
   int  send_gap = 0;
   int  rx_wait = 0;
   int  hold_left = 0;
   int  holds_asked = 0;
   int  holds_served = 0;
   bit  tx_calm = 1'b0;
   bit  rx_calm = 1'b0;

   camera_parallel_capture_decimator_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock
   always begin
      #HalfPeriod clock = 1'b1;
      #HalfPeriod clock = 1'b0;
   end

   // mismatch reporting, printing capped to keep the log short
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < ReportCap)
         $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(3, 1);
      if (roll < 98) return $urandom_range(10, 4);
      return $urandom_range(40, 20);
   endfunction

   // zero means one, above the limit means the limit
   function automatic int eff_count(input int v, input int maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : v;
   endfunction

   // advance the tracked sequencer by one pin word and return its result word
   function automatic cpcd_pkg::rsp_type step_capture(input cpcd_pkg::req_type w);
      cpcd_pkg::rsp_type r;
      r = '0;
      case (seq_now)
         SEQ_IDLE:   if (w.start_req) seq_now = SEQ_VS_HI;
         SEQ_VS_HI:  if (w.vsync) seq_now = SEQ_VS_LO;
         SEQ_VS_LO: begin
            if (!w.vsync) begin
               next_addr  = '0;
               lines_done = 0;
               seq_now    = SEQ_HS_HI1;
            end
         end
         SEQ_HS_HI1: if (w.hsync) seq_now = SEQ_HS_LO;
         SEQ_HS_LO:  if (!w.hsync) seq_now = SEQ_HS_HI2;
         SEQ_HS_HI2: begin
            if (w.hsync) begin
               pixels_done = 0;
               seq_now     = SEQ_PA_HI;
            end
         end
         SEQ_PA_HI, SEQ_PB_HI: begin
            if (w.pixel_clock) begin
               r.byte_valid   = 1'b1;
               r.byte_address = next_addr;
               r.byte_data    = w.data_byte;
               next_addr      = next_addr + cpcd_pkg::AddrWidth'(1);
               seq_now        = (seq_now == SEQ_PA_HI) ? SEQ_PA_LO : SEQ_PB_LO;
            end
         end
         SEQ_PA_LO:  if (!w.pixel_clock) seq_now = SEQ_PB_HI;
         SEQ_PB_LO:  if (!w.pixel_clock) seq_now = SEQ_S1_HI;
         SEQ_S1_HI:  if (w.pixel_clock) seq_now = SEQ_S1_LO;
         SEQ_S1_LO:  if (!w.pixel_clock) seq_now = SEQ_S2_HI;
         SEQ_S2_HI:  if (w.pixel_clock) seq_now = SEQ_S2_LO;
         SEQ_S2_LO: begin
            // end of a pixel: count it, maybe end the line and the frame
            if (!w.pixel_clock) begin
               pixels_done = (pixels_done + 1) & 'h3FF;
               if (pixels_done >= eff_count(int'(pixel_cfg),
                                            cpcd_pkg::MaxPixelsDefault)) begin
                  lines_done = (lines_done + 1) & 'h7FF;
                  if (lines_done >= eff_count(int'(line_cfg),
                                              cpcd_pkg::MaxLinesDefault)) begin
                     r.frame_done = 1'b1;
                     seq_now      = SEQ_IDLE;
                  end else begin
                     seq_now = SEQ_HS_HI1;
                  end
               end else begin
                  seq_now = SEQ_PA_HI;
               end
            end
         end
         default: seq_now = SEQ_IDLE;
      endcase
      r.busy_res = (seq_now != SEQ_IDLE);
      return r;
   endfunction

   // queue one pin word together with its result word
   task automatic push_word(input cpcd_pkg::req_type w);
      pin_words.push_back(w);
      capture_results_q.push_back(step_capture(w));
   endtask

   task automatic push_pins(input int st, input int vs, input int hs, input int pc,
                            input logic [cpcd_pkg::DataWidth-1:0] d);
      cpcd_pkg::req_type w;
      w.start_req   = st[0];
      w.vsync       = vs[0];
      w.hsync       = hs[0];
      w.pixel_clock = pc[0];
      w.data_byte   = d;
      push_word(w);
   endtask

   // pick pins that move the sequencer on with the given odds, else hold the level, or random pins at the noise odds
   function automatic cpcd_pkg::req_type pick_pins(input int adv_pct, input int noise_pct);
      logic [ReqBits-1:0] raw;
      cpcd_pkg::req_type w;
      bit adv;
      raw = ReqBits'($urandom);
      w   = raw;
      if ($urandom_range(99) < noise_pct) return w;
      adv = ($urandom_range(99) < adv_pct);
      case (seq_now)
         SEQ_IDLE:               w.start_req = adv;
         SEQ_VS_HI:              w.vsync = adv;
         SEQ_VS_LO:              w.vsync = !adv;
         SEQ_HS_HI1, SEQ_HS_HI2: w.hsync = adv;
         SEQ_HS_LO:              w.hsync = !adv;
         SEQ_PA_HI, SEQ_PB_HI, SEQ_S1_HI, SEQ_S2_HI: w.pixel_clock = adv;
         default:                w.pixel_clock = !adv;
      endcase
      // a stray start while busy now and then
      if (seq_now != SEQ_IDLE) w.start_req = ($urandom_range(15) == 0);
      return w;
   endfunction

   task automatic feed(input int n, input int adv_pct, input int noise_pct);
      for (int k = 0; k < n; k++) push_word(pick_pins(adv_pct, noise_pct));
   endtask

   // run the current frame to its end, starting one if idle
   task automatic play_frame();
      int guard;
      guard = 0;
      do begin
         push_word(pick_pins(100, 0));
         guard++;
      end while (seq_now != SEQ_IDLE && guard < 8000);
   endtask

   task automatic wait_drained();
      while (pin_words.size() != 0 || capture_results_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register write, only issued while the pipeline is empty
   task automatic write_reg(input logic [cpcd_pkg::CsrIndexWidth-1:0] idx,
                            input int val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val[cpcd_pkg::CsrDataWidth-1:0];
      do @(posedge clock); while (!csr_ready);
      if (idx == cpcd_pkg::CsrLineCount) line_cfg = val[cpcd_pkg::LineCountWidth-1:0];
      else pixel_cfg = val[cpcd_pkg::PixelCountWidth-1:0];
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // acceptance of the pin word at this edge
   always @(posedge clock) begin
      req_fire <= !reset && req_valid && !req_stall;
   end

   // pin word driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || req_fire) begin
         if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (pin_words.size() != 0) begin
            req_valid <= 1'b1;
            req_data  <= pin_words.pop_front();
            send_gap  <= tx_calm ? 0 : pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, counted here
   always @(negedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (holds_served < holds_asked) begin
         holds_served <= holds_served + 1;
         hold_left    <= LongHold;
      end
   end

   // receiver stall
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rx_wait   <= 0;
      end else if (hold_left != 0 || rx_wait != 0) begin
         rsp_stall <= 1'b1;
         if (rx_wait != 0) rx_wait <= rx_wait - 1;
      end else begin
         rsp_stall <= 1'b0;
         rx_wait   <= rx_calm ? 0 : pick_gap();
      end
   end

   // result word check against the oldest owed word
   always @(posedge clock) begin : rsp_check
      cpcd_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (capture_results_q.size() == 0) begin
            report_mismatch("unexpected word", 32'(rsp_data.byte_address), 32'd0);
         end else begin
            want = capture_results_q.pop_front();
            if (rsp_data.byte_valid !== want.byte_valid)
               report_mismatch("byte_valid", 32'(rsp_data.byte_valid),
                               32'(want.byte_valid));
            if (rsp_data.byte_address !== want.byte_address)
               report_mismatch("byte_address", 32'(rsp_data.byte_address),
                               32'(want.byte_address));
            if (rsp_data.byte_data !== want.byte_data)
               report_mismatch("byte_data", 32'(rsp_data.byte_data),
                               32'(want.byte_data));
            if (rsp_data.frame_done !== want.frame_done)
               report_mismatch("frame_done", 32'(rsp_data.frame_done),
                               32'(want.frame_done));
            if (rsp_data.busy_res !== want.busy_res)
               report_mismatch("busy_res", 32'(rsp_data.busy_res),
                               32'(want.busy_res));
         end
      end
   end

   // stimulus
   initial begin : stimulus
      int lines_pick;
      int pixels_pick;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // idle words, then a start whose own pins are not looked at
      push_pins(0, 0, 0, 0, 8'h00);
      push_pins(0, 1, 1, 1, 8'hFF);
      push_pins(1, 1, 1, 1, 8'hFF);
      push_pins(0, 1, 0, 0, 8'h00);
      // start while busy is ignored
      push_pins(1, 1, 0, 0, 8'h00);
      push_pins(0, 0, 1, 1, 8'hFF);
      // hsync high, low, high skips a line
      push_pins(0, 0, 1, 0, 8'h00);
      push_pins(0, 0, 0, 1, 8'h00);
      push_pins(0, 0, 1, 0, 8'h00);
      // two kept bytes, then two skipped pixel clock periods
      push_pins(0, 0, 1, 1, 8'h00);
      push_pins(0, 0, 1, 0, 8'hFF);
      push_pins(0, 1, 1, 1, 8'hFF);
      push_pins(0, 0, 1, 0, 8'h5A);
      push_pins(0, 0, 1, 1, 8'hA5);
      push_pins(0, 0, 0, 0, 8'h00);
      push_pins(0, 0, 0, 1, 8'h00);
      push_pins(0, 0, 0, 0, 8'h00);
      wait_drained();

      // shrink both counts mid-frame: the counters already reach them
      write_reg(cpcd_pkg::CsrLineCount, 1);
      write_reg(cpcd_pkg::CsrPixelCount, 1);
      for (int k = 0; k < 4; k++) begin
         push_pins(0, 0, 1, 1, (k == 0) ? 8'h80 : 8'h01);
         push_pins(0, 0, 1, 0, 8'h00);
      end
      wait_drained();

      // zero counts act as one
      write_reg(cpcd_pkg::CsrLineCount, 0);
      write_reg(cpcd_pkg::CsrPixelCount, 0);
      play_frame();
      play_frame();
      wait_drained();

      // counts above the limit, then at the limit
      write_reg(cpcd_pkg::CsrLineCount, 'h1FF);
      write_reg(cpcd_pkg::CsrPixelCount, 'h3FF);
      feed(200, 60, 5);
      wait_drained();
      write_reg(cpcd_pkg::CsrLineCount, cpcd_pkg::MaxLinesDefault);
      write_reg(cpcd_pkg::CsrPixelCount, cpcd_pkg::MaxPixelsDefault);
      feed(150, 60, 5);
      wait_drained();

      // random frames with small counts, some phases noisy or without idling
      for (int ph = 0; ph < 8; ph++) begin
         lines_pick  = $urandom_range(4, 1);
         pixels_pick = $urandom_range(6, 1);
         write_reg(cpcd_pkg::CsrLineCount, lines_pick);
         write_reg(cpcd_pkg::CsrPixelCount, pixels_pick);
         tx_calm = ($urandom_range(3) == 0);
         rx_calm = ($urandom_range(3) == 0);
         if (ph == 1) begin
            tx_calm = 1'b1;
            rx_calm = 1'b1;
            holds_asked++;
         end
         feed(100, 55, (ph % 3 == 2) ? 30 : 8);
         play_frame();
         wait_drained();
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (capture_results_q.size() != 0)
         report_mismatch("words never returned", capture_results_q.size(), 32'd0);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
